// File: hw/rtl/cst_pkg.sv
package cst_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int LENGTH_BITS = 12;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   localparam int KW_INT = 0;
   localparam int KW_DOUBLE = 1;
   localparam int KW_PRINT = 2;
   localparam int KW_COUNT = 3;

   localparam logic [2:0] KW_ALL = 3'b111;

   // keyword spellings, left aligned in six bytes
   localparam logic [47:0] KW_INT_TEXT = {"int", 24'h0};
   localparam logic [47:0] KW_DOUBLE_TEXT = "double";
   localparam logic [47:0] KW_PRINT_TEXT = {"print", 8'h0};

   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [LENGTH_BITS-1:0] length_type;

   typedef enum logic [3:0] {
      KIND_EOF,
      KIND_ASSIGN,
      KIND_PLUS,
      KIND_MINUS,
      KIND_STAR,
      KIND_SLASH,
      KIND_SEMI,
      KIND_LPAREN,
      KIND_RPAREN,
      KIND_INT_LIT,
      KIND_DOUBLE_LIT,
      KIND_INT_KW,
      KIND_DOUBLE_KW,
      KIND_PRINT,
      KIND_IDENT,
      KIND_ERROR
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER
   } mode_type;

   typedef struct packed {
      kind_type   kind;
      offset_type start_offset;
      length_type token_length;
   } token_type;

   // an entry holds the one or two tokens of a request; a lone token sits in second
   typedef struct packed {
      logic      two;
      token_type first;
      token_type second;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_ident_char(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   function automatic kind_type op_kind(logic [7:0] c);
      kind_type k;
      unique case (c)
         "=":     k = KIND_ASSIGN;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         "/":     k = KIND_SLASH;
         ";":     k = KIND_SEMI;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic length_type kw_len(int i);
      length_type n;
      unique case (i)
         KW_INT:    n = LENGTH_BITS'(3);
         KW_DOUBLE: n = LENGTH_BITS'(6);
         default:   n = LENGTH_BITS'(5);
      endcase
      return n;
   endfunction

   function automatic kind_type kw_kind(int i);
      kind_type k;
      unique case (i)
         KW_INT:    k = KIND_INT_KW;
         KW_DOUBLE: k = KIND_DOUBLE_KW;
         default:   k = KIND_PRINT;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] kw_byte(int i, logic [2:0] idx);
      logic [47:0] text;
      logic [7:0]  b;
      unique case (i)
         KW_INT:    text = KW_INT_TEXT;
         KW_DOUBLE: text = KW_DOUBLE_TEXT;
         default:   text = KW_PRINT_TEXT;
      endcase
      if (idx > 3'd5) begin
         b = 8'h0;
      end else begin
         b = text[47 - 8 * int'(idx) -: 8];
      end
      return b;
   endfunction

   // drop keywords that no longer match the identifier as a prefix
   function automatic logic [2:0] narrow(logic [2:0] cand, length_type count, logic [7:0] c);
      logic [2:0] r;
      r = cand;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (count >= kw_len(i) || kw_byte(i, count[2:0]) != c) begin
            r[i] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic kind_type ident_kind(logic [2:0] cand, length_type count);
      kind_type k;
      k = KIND_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (cand[i] && count == kw_len(i)) begin
            k = kw_kind(i);
         end
      end
      return k;
   endfunction

endpackage

// File: hw/rtl/cst_if.sv
interface cst_req_if;
   import cst_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_input;

   modport source (output valid, output ch, output end_of_input, input ready);
   modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

interface cst_rsp_if;
   import cst_pkg::*;

   logic       valid;
   logic       ready;
   kind_type   kind;
   offset_type start_offset;
   length_type token_length;
   logic       last_of_run;

   modport source (
      output valid, output kind, output start_offset, output token_length,
      output last_of_run, input ready
   );
   modport sink (
      input valid, input kind, input start_offset, input token_length,
      input last_of_run, output ready
   );
endinterface

// File: hw/rtl/cst_front.sv
module cst_front (
   input  logic                     clock,
   input  logic                     reset,
   cst_req_if.sink                  req_bus,
   input  cst_pkg::fifo_status_type status,
   output logic                     push,
   output cst_pkg::entry_type       push_entry
);
   import cst_pkg::*;

   mode_type   mode_ff, mode_in;
   logic       dot_ff, dot_in;
   offset_type start_ff, start_in;
   length_type count_ff, count_in;
   offset_type pos_ff, pos_in;
   logic [2:0] cand_ff, cand_in;

   logic       accept;
   logic [7:0] c;
   logic       idle_go;
   logic       flush_v, new_v;
   token_type  pending_tok, new_tok;
   length_type count_grown;

   assign req_bus.ready = !status.full;
   assign accept = req_bus.valid && req_bus.ready;
   assign c = req_bus.ch;
   assign count_grown = (count_ff != '1) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      pending_tok.kind = (mode_ff == MODE_IDENT) ? ident_kind(cand_ff, count_ff)
                       : (dot_ff ? KIND_DOUBLE_LIT : KIND_INT_LIT);
      pending_tok.start_offset = start_ff;
      pending_tok.token_length = count_ff;
   end

   always_comb begin
      mode_in = mode_ff;
      dot_in = dot_ff;
      start_in = start_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      cand_in = cand_ff;
      idle_go = 1'b0;
      flush_v = 1'b0;
      new_v = 1'b0;
      new_tok.kind = KIND_EOF;
      new_tok.start_offset = pos_ff;
      new_tok.token_length = '0;
      if (req_bus.end_of_input) begin
         flush_v = (mode_ff != MODE_IDLE);
         new_v = 1'b1;
         mode_in = MODE_IDLE;
         dot_in = 1'b0;
         start_in = '0;
         count_in = '0;
         pos_in = '0;
         cand_in = KW_ALL;
      end else begin
         unique case (mode_ff)
            MODE_IDENT: begin
               if (is_ident_char(c)) begin
                  cand_in = narrow(cand_ff, count_ff, c);
                  count_in = count_grown;
               end else begin
                  flush_v = 1'b1;
                  idle_go = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(c) || (c == "." && !dot_ff)) begin
                  dot_in = dot_ff || (c == ".");
                  count_in = count_grown;
               end else begin
                  flush_v = 1'b1;
                  idle_go = 1'b1;
               end
            end
            default: begin
               idle_go = 1'b1;
            end
         endcase
         if (idle_go) begin
            mode_in = MODE_IDLE;
            dot_in = 1'b0;
            count_in = '0;
            cand_in = KW_ALL;
            if (is_alpha(c) || c == "_") begin
               mode_in = MODE_IDENT;
               start_in = pos_ff;
               cand_in = narrow(KW_ALL, '0, c);
               count_in = LENGTH_BITS'(1);
            end else if (is_digit(c)) begin
               mode_in = MODE_NUMBER;
               start_in = pos_ff;
               count_in = LENGTH_BITS'(1);
            end else if (!is_space(c)) begin
               new_v = 1'b1;
               new_tok.kind = op_kind(c);
               new_tok.token_length = LENGTH_BITS'(1);
            end
         end
         pos_in = pos_ff + 1'b1;
      end
   end

   assign push = accept && (flush_v || new_v);
   assign push_entry.two = flush_v && new_v;
   assign push_entry.first = pending_tok;
   assign push_entry.second = new_v ? new_tok : pending_tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         dot_ff <= 1'b0;
         start_ff <= '0;
         count_ff <= '0;
         pos_ff <= '0;
         cand_ff <= KW_ALL;
      end else if (accept) begin
         mode_ff <= mode_in;
         dot_ff <= dot_in;
         start_ff <= start_in;
         count_ff <= count_in;
         pos_ff <= pos_in;
         cand_ff <= cand_in;
      end
   end

endmodule

// File: hw/rtl/cst_fifo.sv
module cst_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cst_pkg::entry_type       push_entry,
   input  logic                     pop,
   output cst_pkg::entry_type       head_entry,
   output cst_pkg::fifo_status_type status
);
   import cst_pkg::*;

   entry_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;

   assign status.full = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("queue count out of range");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a write");

endmodule

// File: hw/rtl/cst_back.sv
module cst_back (
   input  logic                     clock,
   input  logic                     reset,
   input  cst_pkg::entry_type       head_entry,
   input  cst_pkg::fifo_status_type status,
   output logic                     pop,
   cst_rsp_if.source                rsp_bus
);
   import cst_pkg::*;

   logic      valid_ff, valid_in;
   logic      second_ff, second_in;
   token_type tok_ff, tok_in;
   logic      last_ff, last_in;
   logic      load;

   assign load = !valid_ff || rsp_bus.ready;

   always_comb begin
      pop = 1'b0;
      valid_in = valid_ff && !rsp_bus.ready;
      second_in = second_ff;
      tok_in = tok_ff;
      last_in = last_ff;
      if (load) begin
         if (second_ff) begin
            valid_in = 1'b1;
            tok_in = head_entry.second;
            last_in = 1'b1;
            second_in = 1'b0;
            pop = 1'b1;
         end else if (!status.empty) begin
            valid_in = 1'b1;
            if (head_entry.two) begin
               tok_in = head_entry.first;
               last_in = 1'b0;
               second_in = 1'b1;
            end else begin
               tok_in = head_entry.second;
               last_in = 1'b1;
               pop = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      last_ff <= last_in;
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.kind = tok_ff.kind;
   assign rsp_bus.start_offset = tok_ff.start_offset;
   assign rsp_bus.token_length = tok_ff.token_length;
   assign rsp_bus.last_of_run = last_ff;

endmodule

// File: hw/rtl/char_stream_tokenizer_top.sv
// character stream tokenizer
// req_bus takes one source byte per request in ch, or an end marker when
// end_of_input is set (ch is then ignored). rsp_bus gives tokens: kind,
// start_offset, token_length and last_of_run, which marks the final token
// caused by a request. a request gives zero, one or two tokens; the end
// marker flushes a pending token, adds an eof token and restarts offsets at 0.
// the front scanner takes one byte per cycle while the queue is not full and
// writes the tokens of a request as one entry into a four-entry queue; the
// back stage sends one token per cycle from that queue through an output
// register while rsp_bus.ready is high. the first token of a request is
// written into the queue and then loaded into the output register before it
// is valid on rsp_bus. a request that closes a token and opens an operator
// gives two tokens, sent one after the other; the queue absorbs such bursts.
// a token held by a stalled receiver stays on rsp_bus; once the queue is full
// req_bus.ready drops until the back stage frees an entry.
// reset (synchronous) empties the queue and clears the scanner state.
module char_stream_tokenizer_top (
   input  logic       clock,
   input  logic       reset,
   cst_req_if.sink    req_bus,
   cst_rsp_if.source  rsp_bus
);
   import cst_pkg::*;

   logic            push;
   logic            pop;
   entry_type       push_entry;
   entry_type       head_entry;
   fifo_status_type status;

   cst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .status     (status),
      .push       (push),
      .push_entry (push_entry)
   );

   cst_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (status)
   );

   cst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .status     (status),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

// File: verif/char_stream_tokenizer_top_tb.sv
`timescale 1ns / 1ps

module char_stream_tokenizer_top_tb;
   import cst_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 10;

   typedef struct packed {
      kind_type   kind;
      offset_type start_offset;
      length_type token_length;
      logic       last_of_run;
   } lexeme_t;

   logic clock = 1'b0;
   logic reset;

   cst_req_if req_bus ();
   cst_rsp_if rsp_bus ();

   char_stream_tokenizer_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // scanner image kept by the testbench
   mode_type   scan_mode;
   logic       scan_dot;
   offset_type scan_start;
   length_type scan_len;
   offset_type scan_pos;
   logic [2:0] scan_keywords;

   lexeme_t expected_tokens[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int request_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   function automatic logic letter_byte(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic digit_byte(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic blank_byte(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic string keyword_spelling(int k);
      case (k)
         KW_INT:    return "int";
         KW_DOUBLE: return "double";
         default:   return "print";
      endcase
   endfunction

   function automatic kind_type keyword_token(int k);
      case (k)
         KW_INT:    return KIND_INT_KW;
         KW_DOUBLE: return KIND_DOUBLE_KW;
         default:   return KIND_PRINT;
      endcase
   endfunction

   function automatic kind_type operator_token(logic [7:0] c);
      case (c)
         "=":     return KIND_ASSIGN;
         "+":     return KIND_PLUS;
         "-":     return KIND_MINUS;
         "*":     return KIND_STAR;
         "/":     return KIND_SLASH;
         ";":     return KIND_SEMI;
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         default: return KIND_ERROR;
      endcase
   endfunction

   function automatic void clear_scan();
      scan_mode = MODE_IDLE;
      scan_dot = 1'b0;
      scan_len = '0;
      scan_keywords = 3'b111;
   endfunction

   // keep only keywords that still match the word so far as a prefix
   function automatic void prune_keywords(logic [7:0] c);
      string s;
      for (int k = 0; k < KW_COUNT; k++) begin
         s = keyword_spelling(k);
         if (scan_len >= s.len() || s[scan_len] != c) begin
            scan_keywords[k] = 1'b0;
         end
      end
   endfunction

   function automatic void grow_word();
      if (scan_len != '1) begin
         scan_len = scan_len + 1'b1;
      end
   endfunction

   function automatic lexeme_t close_word();
      lexeme_t t;
      string s;
      t.start_offset = scan_start;
      t.token_length = scan_len;
      t.last_of_run = 1'b0;
      if (scan_mode == MODE_IDENT) begin
         t.kind = KIND_IDENT;
         for (int k = 0; k < KW_COUNT; k++) begin
            s = keyword_spelling(k);
            if (scan_keywords[k] && scan_len == s.len()) begin
               t.kind = keyword_token(k);
            end
         end
      end else begin
         t.kind = scan_dot ? KIND_DOUBLE_LIT : KIND_INT_LIT;
      end
      clear_scan();
      return t;
   endfunction

   function automatic lexeme_t single_token(kind_type k, offset_type at, length_type len);
      lexeme_t t;
      t.kind = k;
      t.start_offset = at;
      t.token_length = len;
      t.last_of_run = 1'b0;
      return t;
   endfunction

   function automatic void predict_tokens(logic marker, logic [7:0] c);
      lexeme_t    made[0:1];
      int         n;
      offset_type here;
      n = 0;
      here = scan_pos;
      if (marker) begin
         if (scan_mode != MODE_IDLE) begin
            made[n] = close_word();
            n++;
         end
         made[n] = single_token(KIND_EOF, here, '0);
         n++;
         clear_scan();
         scan_start = '0;
         scan_pos = '0;
      end else begin
         if (scan_mode == MODE_IDENT) begin
            if (letter_byte(c) || digit_byte(c) || c == "_") begin
               prune_keywords(c);
               grow_word();
            end else begin
               made[n] = close_word();
               n++;
            end
         end else if (scan_mode == MODE_NUMBER) begin
            if (digit_byte(c) || (c == "." && !scan_dot)) begin
               if (c == ".") begin
                  scan_dot = 1'b1;
               end
               grow_word();
            end else begin
               made[n] = close_word();
               n++;
            end
         end
         if (scan_mode == MODE_IDLE) begin
            if (letter_byte(c) || c == "_") begin
               scan_mode = MODE_IDENT;
               scan_start = here;
               scan_len = '0;
               scan_keywords = 3'b111;
               prune_keywords(c);
               scan_len = length_type'(1);
            end else if (digit_byte(c)) begin
               scan_mode = MODE_NUMBER;
               scan_start = here;
               scan_len = length_type'(1);
               scan_dot = 1'b0;
            end else if (!blank_byte(c)) begin
               made[n] = single_token(operator_token(c), here, length_type'(1));
               n++;
            end
         end
         scan_pos = here + 1'b1;
      end
      if (n > 0) begin
         made[n-1].last_of_run = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         expected_tokens.push_back(made[i]);
      end
   endfunction

   task automatic send_request(input logic marker, input logic [7:0] c);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.ch <= c;
      req_bus.end_of_input <= marker;
      do @(posedge clock); while (!req_bus.ready);
      predict_tokens(marker, c);
      request_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_request(1'b0, s[i]);
      end
   endtask

   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_pace(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   function automatic logic [7:0] pick_blank();
      int i;
      i = $urandom_range(5);
      return (i == 0) ? 8'h20 : 8'(8 + i);
   endfunction

   function automatic logic [7:0] pick_digit();
      return "0" + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] pick_word_head();
      case ($urandom_range(2))
         0:       return "a" + 8'($urandom_range(25));
         1:       return "A" + 8'($urandom_range(25));
         default: return "_";
      endcase
   endfunction

   function automatic logic [7:0] pick_word_byte();
      return ($urandom_range(3) == 0) ? pick_digit() : pick_word_head();
   endfunction

   function automatic logic [7:0] pick_operator();
      string ops;
      ops = "=+-*/;()";
      return ops[$urandom_range(7)];
   endfunction

   // one random lexeme, often glued straight onto the next one
   task automatic emit_random_lexeme(input logic allow_marker);
      int    pick;
      string word;
      pick = $urandom_range(99);
      if (pick < 10) begin
         send_text(keyword_spelling($urandom_range(KW_COUNT - 1)));
      end else if (pick < 18) begin
         word = keyword_spelling($urandom_range(KW_COUNT - 1));
         if ($urandom_range(1) == 0) begin
            send_text(word.substr(0, $urandom_range(word.len() - 2)));
         end else begin
            send_text(word);
            send_request(1'b0, pick_word_byte());
         end
      end else if (pick < 36) begin
         send_request(1'b0, pick_word_head());
         repeat ($urandom_range(7)) send_request(1'b0, pick_word_byte());
      end else if (pick < 54) begin
         repeat ($urandom_range(1, 5)) send_request(1'b0, pick_digit());
         if ($urandom_range(2) == 0) begin
            send_request(1'b0, ".");
            repeat ($urandom_range(3)) send_request(1'b0, pick_digit());
            if ($urandom_range(3) == 0) begin
               send_request(1'b0, ".");
            end
         end
      end else if (pick < 70) begin
         send_request(1'b0, pick_operator());
      end else if (pick < 80) begin
         send_request(1'b0, pick_blank());
      end else if (pick < 88) begin
         send_request(1'b0, 8'($urandom_range(255)));
      end else if (pick < 91 && allow_marker) begin
         send_request(1'b1, 8'($urandom_range(255)));
      end
      if ($urandom_range(1) == 0) begin
         send_request(1'b0, pick_blank());
      end
   endtask

   task automatic test_operators();
      set_pace(0, 0);
      send_text("x=(y+1)*z-2/3;");
   endtask

   // keywords, a keyword prefix and every blank byte; end marker closes a word
   task automatic test_keywords_and_blanks();
      send_text("int");
      send_request(1'b0, 8'h09);
      send_text("double");
      send_request(1'b0, 8'h0a);
      send_text("print");
      send_request(1'b0, 8'h0b);
      send_request(1'b0, 8'h0c);
      send_request(1'b0, 8'h0d);
      send_request(1'b0, 8'h20);
      send_text("pri");
      send_request(1'b1, 8'h00);
   endtask

   task automatic test_numbers_and_errors();
      send_text("5.5 7..2");
      send_request(1'b0, 8'h00);
      send_request(1'b0, 8'hff);
      send_request(1'b0, 8'h80);
      send_request(1'b0, "$");
      send_request(1'b1, 8'hff);
      wait_until_drained();
   endtask

   task automatic test_long_tokens();
      set_pace(0, 0);
      send_text("print");
      repeat (60) send_request(1'b0, pick_word_byte());
      send_request(1'b0, ";");
      send_text("int");
      repeat (40) send_request(1'b0, pick_word_byte());
      send_request(1'b0, "(");
      send_request(1'b0, "9");
      repeat (20) send_request(1'b0, pick_digit());
      send_request(1'b0, ".");
      repeat (20) send_request(1'b0, pick_digit());
      send_request(1'b0, ".");
      wait_until_drained();
   endtask

   task automatic test_pause_mid_token();
      set_pace(59, 0);
      send_text("coun");
      wait_until_drained();
      send_text("ter=1.5;");
      wait_until_drained();
   endtask

   task automatic test_random_text(input int send_pct, input int recv_pct, input int count);
      int first;
      set_pace(send_pct, recv_pct);
      first = request_count;
      while (request_count - first < count) begin
         emit_random_lexeme(1'b1);
      end
      wait_until_drained();
   endtask

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      lexeme_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_tokens.size() == 0) begin
            mismatch_count++;
            $display("%0t: no token expected, actual kind %0d offset %0d length %0d",
                     $time, rsp_bus.kind, rsp_bus.start_offset, rsp_bus.token_length);
         end else begin
            want = expected_tokens.pop_front();
            report_field("kind", want.kind, rsp_bus.kind);
            report_field("start_offset", want.start_offset, rsp_bus.start_offset);
            report_field("token_length", want.token_length, rsp_bus.token_length);
            report_field("last_of_run", want.last_of_run, rsp_bus.last_of_run);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d tokens outstanding",
                  cycle_count, expected_tokens.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.ch = 8'h00;
      req_bus.end_of_input = 1'b0;
      rsp_bus.ready = 1'b0;
      clear_scan();
      scan_start = '0;
      scan_pos = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_operators();
      test_keywords_and_blanks();
      test_numbers_and_errors();
      test_long_tokens();
      test_random_text(0, 0, 215);
      test_random_text(59, 0, 215);
      test_pause_mid_token();
      test_random_text(0, 59, 215);
      test_random_text(34, 34, 215);

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_tokens.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
